@@ src/irp_pkg.sv @@
// Shared types, codes and constants of the I2C remote-panel responder.
`timescale 1ns / 1ps

package irp_pkg;

  // Reset values of the configuration registers.
  localparam logic [6:0] OWN_ADDRESS_RESET = 7'h18;
  localparam logic [7:0] NONE_CODE_RESET   = 8'h00;
  localparam logic [7:0] STATUS_CODE_RESET = 8'h01;

  localparam int FRAME_DEPTH_DEFAULT = 16;

  // Only the first KEEP_BYTES bytes of a frame are ever looked at again.
  localparam int KEEP_BYTES    = 12;
  localparam int CAPTURE_FIRST = 3;
  localparam int CAPTURE_LEN   = 9;
  localparam int IDX_W         = $clog2(CAPTURE_LEN);

  localparam int QUEUE_DEPTH = 4;

  // Frame header bytes.
  localparam logic [7:0] BYTE_LEAD       = 8'h00;
  localparam logic [7:0] BYTE_STATUS_REG = 8'h2b;
  localparam logic [7:0] BYTE_STATUS_LEN = 8'h09;
  localparam logic [7:0] BYTE_ACK_REG    = 8'h2a;
  localparam logic [7:0] BYTE_BUTTON_REG = 8'h34;
  localparam logic [7:0] BYTE_ONE        = 8'h01;

  // Reply codes.
  localparam logic [7:0] ACK_DEFAULT = 8'h01;
  localparam logic [7:0] ACK_SELECT  = 8'h81;
  localparam logic [7:0] ACK_STATUS  = 8'h09;
  localparam logic [7:0] ACK_BUTTON  = 8'h19;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_BUTTON = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_OWN_ADDRESS = 2'd0,
    CFG_NONE_CODE   = 2'd1,
    CFG_STATUS_CODE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_STARTING = 4'b0010,
    PH_WAITING  = 4'b0100,
    PH_CAPTURED = 4'b1000
  } phase_t;

  // One output run: a response to the master or a captured display run.
  typedef struct packed {
    logic                              capture;
    logic [IDX_W-1:0]                  last_idx;
    logic [CAPTURE_LEN-1:0][7:0]       bytes;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ src/irp_if.sv @@
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps

interface irp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       end_of_write;
  logic [7:0] button_code;

  modport source (output valid, op, data_byte, end_of_write, button_code, input ready);
  modport sink   (input valid, op, data_byte, end_of_write, button_code, output ready);
endinterface

interface irp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_capture;
  logic [3:0] byte_index;
  logic       last_of_run;

  modport source (output valid, out_byte, is_capture, byte_index, last_of_run, input ready);
  modport sink   (input valid, out_byte, is_capture, byte_index, last_of_run, output ready);
endinterface

interface irp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/irp_front.sv @@
// Front end: collects frames, keeps reply and capture state, issues output runs.
`timescale 1ns / 1ps

module irp_front #(
  parameter int FRAME_DEPTH = irp_pkg::FRAME_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  irp_in_if.sink         req,
  irp_cfg_if.sink        cfg,
  input  irp_pkg::qstat_t qstat,
  output logic           push,
  output irp_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int KB = irp_pkg::KEEP_BYTES;

  logic [6:0]          own_address;
  logic [7:0]          none_code;
  logic [7:0]          status_code;

  logic [KB-1:0][7:0]  frame;
  logic [CW-1:0]       count;
  logic [7:0]          check;
  logic                reply_is_read, reply_is_read_next;
  logic [7:0]          reply_ack, reply_ack_next;
  logic [7:0]          reply_data, reply_data_next;
  logic [7:0]          pending, pending_next;
  irp_pkg::phase_t     phase, phase_next;

  logic                accept;
  irp_pkg::op_t        op;
  logic [7:0]          seed;
  logic                room;
  logic [KB-1:0][7:0]  frm_now;
  logic [7:0]          chk_now;
  logic [CW-1:0]       n_now;
  logic                wr_frame, rd_setup, hdr_status, hdr_ack, hdr_button, capture_go;

  assign req.ready = !qstat.full;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign op        = irp_pkg::op_t'(req.op);
  assign seed      = {own_address, 1'b0};
  assign room      = count < CW'(FRAME_DEPTH);

  // Frame state as it stands once the current byte is taken in.
  always_comb begin
    for (int i = 0; i < KB; i++) begin
      frm_now[i] = (room && count == CW'(i)) ? req.data_byte : frame[i];
    end
    if (room) begin
      chk_now = ((count == '0) ? seed : check) ^ req.data_byte;
      n_now   = count + CW'(1);
    end else begin
      chk_now = check;
      n_now   = count;
    end
  end

  assign wr_frame   = n_now > CW'(3) && chk_now == 8'h00 && frm_now[0] == irp_pkg::BYTE_LEAD;
  assign rd_setup   = n_now == CW'(3);
  assign hdr_status = frm_now[1] == irp_pkg::BYTE_STATUS_REG &&
                      frm_now[2] == irp_pkg::BYTE_STATUS_LEN;
  assign hdr_ack    = frm_now[1] == irp_pkg::BYTE_ACK_REG && frm_now[2] == irp_pkg::BYTE_ONE;
  assign hdr_button = frm_now[1] == irp_pkg::BYTE_BUTTON_REG && frm_now[2] == irp_pkg::BYTE_ONE;
  assign capture_go = wr_frame && hdr_status && n_now >= CW'(KB) && phase == irp_pkg::PH_WAITING;

  always_comb begin
    reply_is_read_next = reply_is_read;
    reply_ack_next     = reply_ack;
    reply_data_next    = reply_data;
    pending_next       = pending;
    phase_next         = phase;
    push               = 1'b0;
    cmd                = '0;
    if (accept) begin
      case (op)
        irp_pkg::OP_WRITE: begin
          if (req.end_of_write) begin
            if (wr_frame) begin
              reply_is_read_next = 1'b0;
              if (hdr_status && n_now >= CW'(KB)) begin
                if (capture_go) begin
                  push         = 1'b1;
                  cmd.capture  = 1'b1;
                  cmd.last_idx = irp_pkg::IDX_W'(irp_pkg::CAPTURE_LEN - 1);
                  for (int i = 0; i < irp_pkg::CAPTURE_LEN; i++) begin
                    cmd.bytes[i] = frm_now[irp_pkg::CAPTURE_FIRST + i];
                  end
                  phase_next   = irp_pkg::PH_CAPTURED;
                  pending_next = none_code;
                end
              end else if (hdr_ack) begin
                reply_ack_next = irp_pkg::ACK_SELECT;
              end else begin
                reply_ack_next = irp_pkg::ACK_DEFAULT;
              end
            end else if (rd_setup) begin
              reply_is_read_next = 1'b1;
              if (hdr_ack) begin
                if (pending == none_code) begin
                  reply_ack_next = irp_pkg::ACK_DEFAULT;
                end else if (pending == status_code) begin
                  reply_ack_next = irp_pkg::ACK_STATUS;
                  if (phase == irp_pkg::PH_STARTING) phase_next = irp_pkg::PH_WAITING;
                end else begin
                  reply_ack_next = irp_pkg::ACK_BUTTON;
                end
                reply_data_next = reply_ack_next;
              end else if (hdr_button) begin
                reply_data_next = pending;
                if (phase == irp_pkg::PH_STARTING) phase_next = irp_pkg::PH_WAITING;
              end else begin
                reply_ack_next  = irp_pkg::ACK_DEFAULT;
                reply_data_next = irp_pkg::ACK_DEFAULT;
              end
            end
          end
        end
        irp_pkg::OP_READ: begin
          push         = 1'b1;
          cmd.capture  = 1'b0;
          cmd.bytes[0] = reply_ack;
          if (reply_is_read) begin
            cmd.last_idx = irp_pkg::IDX_W'(2);
            cmd.bytes[1] = reply_data;
            cmd.bytes[2] = reply_ack ^ reply_data;
          end else begin
            cmd.last_idx = irp_pkg::IDX_W'(1);
            cmd.bytes[1] = reply_ack;
          end
        end
        irp_pkg::OP_BUTTON: begin
          pending_next = req.button_code;
          phase_next   = irp_pkg::PH_STARTING;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= irp_pkg::OWN_ADDRESS_RESET;
      none_code     <= irp_pkg::NONE_CODE_RESET;
      status_code   <= irp_pkg::STATUS_CODE_RESET;
      count         <= '0;
      check         <= '0;
      reply_is_read <= 1'b0;
      reply_ack     <= irp_pkg::ACK_DEFAULT;
      reply_data    <= irp_pkg::ACK_DEFAULT;
      pending       <= irp_pkg::NONE_CODE_RESET;
      phase         <= irp_pkg::PH_IDLE;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (irp_pkg::cfg_idx_t'(cfg.index))
          irp_pkg::CFG_OWN_ADDRESS: own_address <= cfg.data[6:0];
          irp_pkg::CFG_NONE_CODE:   none_code   <= cfg.data;
          irp_pkg::CFG_STATUS_CODE: status_code <= cfg.data;
          default: begin
          end
        endcase
      end
      if (accept && op == irp_pkg::OP_WRITE) begin
        count <= req.end_of_write ? '0 : n_now;
        check <= chk_now;
      end
      reply_is_read <= reply_is_read_next;
      reply_ack     <= reply_ack_next;
      reply_data    <= reply_data_next;
      pending       <= pending_next;
      phase         <= phase_next;
    end
  end

  // Frame bytes carry no reset; only bytes written in the current frame are read.
  always_ff @(posedge clk) begin
    if (accept && op == irp_pkg::OP_WRITE) begin
      frame <= frm_now;
    end
  end

endmodule

@@ src/irp_cmd_queue.sv @@
// Short queue of output runs between the front end and the back end.
`timescale 1ns / 1ps

module irp_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  irp_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output irp_pkg::cmd_t   head,
  output irp_pkg::qstat_t qstat
);

  localparam int QD  = irp_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);

  irp_pkg::cmd_t  entries [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  logic           do_push;
  logic           do_pop;

  assign qstat.full  = fill == (QAW+1)'(QD);
  assign qstat.empty = fill == '0;
  assign head        = entries[rd_ptr];
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QD - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QD - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ src/irp_back.sv @@
// Back end: plays out each queued run one byte per beat.
`timescale 1ns / 1ps

module irp_back (
  input  logic            clk,
  input  logic            rst,
  input  irp_pkg::cmd_t   head,
  input  irp_pkg::qstat_t qstat,
  output logic            pop,
  irp_out_if.source       rsp
);

  irp_pkg::cmd_t             cur;
  logic                      busy;
  logic [irp_pkg::IDX_W-1:0] idx;
  logic                      at_last;
  logic                      beat;

  assign at_last         = idx == cur.last_idx;
  assign beat            = busy && rsp.ready;
  assign pop             = !qstat.empty && (!busy || (beat && at_last));

  assign rsp.valid       = busy;
  assign rsp.out_byte    = cur.bytes[idx];
  assign rsp.is_capture  = cur.capture;
  assign rsp.byte_index  = 4'(idx);
  assign rsp.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (beat) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + irp_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

@@ src/i2c_remote_panel_responder.sv @@
// Top level of the I2C remote-panel responder: front end, run queue, back end.
`timescale 1ns / 1ps

// Channel  Role    Beat carries
// req      sink    op, data_byte, end_of_write, button_code
// cfg      sink    index, data (register write, always ready)
// rsp      source  out_byte, is_capture, byte_index, last_of_run
//
// The front end takes one input beat per cycle while the run queue has room.
// Each read request or status capture becomes one run in the queue; the back
// end plays a run out at one beat per cycle while rsp is ready, so a response
// has 2 or 3 beats and a capture 9.
// Reset is synchronous; there is no clearing pass.
// A stalled rsp holds the back end, and the queue fills before req is held.

module i2c_remote_panel_responder #(
  parameter int FRAME_DEPTH = irp_pkg::FRAME_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  irp_in_if.sink    req,
  irp_cfg_if.sink   cfg,
  irp_out_if.source rsp
);

  // Runs issued by the front end.
  logic            push;
  irp_pkg::cmd_t   push_cmd;

  // Queue head for the back end; queue status, shared by both sides.
  irp_pkg::cmd_t   head;
  irp_pkg::qstat_t qstat;
  logic            pop;

  // The front end owns the frame, the check, the reply bytes and the capture
  // phase, and decides at each end of write what the frame asks for.
  irp_front #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cfg   (cfg),
    .qstat (qstat),
    .push  (push),
    .cmd   (push_cmd)
  );

  // The queue lets the front end keep taking bytes while a run drains.
  irp_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // The back end loads the next run in the same cycle the current one ends.
  irp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

@@ tb/tb_i2c_remote_panel_responder.sv @@
// Self-checking testbench of the I2C remote-panel responder: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

// The testbench drives master writes, read requests and button presses into
// the responder. It also writes its three registers between phases.
// A scoreboard class keeps its own copy of the responder state:
//   - the frame bytes and the running XOR check,
//   - the reply ack and data,
//   - the pending button and the capture phase.
// From that state it works out, for every accepted input beat, the result
// beats the block should send. Each accepted result beat is compared field by
// field with the oldest expected beat.
//
// The stimulus starts with a short directed dialogue. It then runs four phases
// of random traffic, each under a different register setting. The largest share of the
// random traffic is well-formed panel dialogue, so that the capture path is
// reached often:
//   - button press,
//   - read setup,
//   - read,
//   - status write with a correct check byte.
// The rest includes:
//   - frames with bad check bytes or a wrong lead byte,
//   - oversized frames,
//   - noise bytes,
//   - no-operation beats,
//   - read requests dropped into the middle of frames.
module tb_i2c_remote_panel_responder;
  import irp_pkg::*;

  localparam int FRAME_DEPTH    = FRAME_DEPTH_DEFAULT;
  localparam int PHASE_ITEMS    = 35;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_READS     = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT   = 18;

  typedef struct packed {
    logic [7:0] value;
    logic       capture;
    logic [3:0] pos;
    logic       last;
  } panel_beat_t;

  // Tracks the responder state and the result beats still owed by the block.
  class panel_scoreboard;
    logic [6:0]  own_address;
    logic [7:0]  none_code;
    logic [7:0]  status_code;
    logic [7:0]  frame [FRAME_DEPTH];
    int unsigned frame_len;
    logic [7:0]  check;
    bit          reply_is_read;
    logic [7:0]  reply_ack;
    logic [7:0]  reply_data;
    logic [7:0]  pending;
    phase_t      phase;
    panel_beat_t expected [$];
    int unsigned items;
    int unsigned beats;
    int unsigned captures;
    int unsigned reg_writes;
    int unsigned mismatches;

    function new();
      own_address = OWN_ADDRESS_RESET;
      none_code   = NONE_CODE_RESET;
      status_code = STATUS_CODE_RESET;
      foreach (frame[i]) frame[i] = 8'h00;
      frame_len     = 0;
      check         = {OWN_ADDRESS_RESET, 1'b0};
      reply_is_read = 1'b0;
      reply_ack     = ACK_DEFAULT;
      reply_data    = ACK_DEFAULT;
      pending       = NONE_CODE_RESET;
      phase         = PH_IDLE;
    endfunction

    function logic [7:0] address_seed();
      return {own_address, 1'b0};
    endfunction

    function void owe(logic [7:0] value, logic capture, int pos, logic last);
      panel_beat_t b;
      b.value   = value;
      b.capture = capture;
      b.pos     = 4'(pos);
      b.last    = last;
      expected.push_back(b);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [7:0] value);
      reg_writes++;
      case (idx)
        CFG_OWN_ADDRESS: begin
          own_address = value[6:0];
          if (frame_len == 0) check = address_seed();
        end
        CFG_NONE_CODE:   none_code = value;
        CFG_STATUS_CODE: status_code = value;
        default: ;
      endcase
    endfunction

    // Sorts out a finished frame: write frame, read setup, or nothing.
    function void classify();
      if (frame_len > 3 && check == 8'h00 && frame[0] == BYTE_LEAD) begin
        reply_is_read = 1'b0;
        if (frame[1] == BYTE_STATUS_REG && frame[2] == BYTE_STATUS_LEN
            && frame_len >= KEEP_BYTES) begin
          // A status write only counts while the remote waits for one.
          if (phase == PH_WAITING) begin
            for (int i = 0; i < CAPTURE_LEN; i++)
              owe(frame[CAPTURE_FIRST + i], 1'b1, i, i == CAPTURE_LEN - 1);
            captures++;
            phase   = PH_CAPTURED;
            pending = none_code;
          end
        end else if (frame[1] == BYTE_ACK_REG && frame[2] == BYTE_ONE) begin
          reply_ack = ACK_SELECT;
        end else begin
          reply_ack = ACK_DEFAULT;
        end
      end else if (frame_len == 3) begin
        reply_is_read = 1'b1;
        if (frame[1] == BYTE_ACK_REG && frame[2] == BYTE_ONE) begin
          // The none test comes first, so it wins when both codes are equal.
          if (pending == none_code) begin
            reply_ack = ACK_DEFAULT;
          end else if (pending == status_code) begin
            reply_ack = ACK_STATUS;
            if (phase == PH_STARTING) phase = PH_WAITING;
          end else begin
            reply_ack = ACK_BUTTON;
          end
          reply_data = reply_ack;
        end else if (frame[1] == BYTE_BUTTON_REG && frame[2] == BYTE_ONE) begin
          reply_data = pending;
          if (phase == PH_STARTING) phase = PH_WAITING;
        end else begin
          reply_ack  = ACK_DEFAULT;
          reply_data = ACK_DEFAULT;
        end
      end
    endfunction

    function void note_input(op_t op, logic [7:0] db, logic eow, logic [7:0] bc);
      logic [7:0] base;
      items++;
      case (op)
        OP_WRITE: begin
          // Bytes past the frame depth are dropped and stay out of the check.
          if (frame_len < FRAME_DEPTH) begin
            base  = (frame_len == 0) ? address_seed() : check;
            check = base ^ db;
            frame[frame_len] = db;
            frame_len++;
          end
          if (eow) begin
            classify();
            frame_len = 0;
            check     = address_seed();
          end
        end
        OP_READ: begin
          owe(reply_ack, 1'b0, 0, 1'b0);
          if (reply_is_read) begin
            owe(reply_data, 1'b0, 1, 1'b0);
            owe(reply_ack ^ reply_data, 1'b0, 2, 1'b1);
          end else begin
            owe(reply_ack, 1'b0, 1, 1'b1);
          end
        end
        OP_BUTTON: begin
          pending = bc;
          phase   = PH_STARTING;
        end
        default: ;
      endcase
    endfunction

    function void check_result(panel_beat_t got);
      panel_beat_t want;
      beats++;
      if (expected.size() == 0) begin
        $error("result beat with nothing expected: out_byte %h is_capture %b byte_index %0d",
               got.value, got.capture, got.pos);
        mismatches++;
        return;
      end
      want = expected.pop_front();
      if (got.value !== want.value) begin
        $error("out_byte: expected %h, actual %h", want.value, got.value);
        mismatches++;
      end
      if (got.capture !== want.capture) begin
        $error("is_capture: expected %b, actual %b", want.capture, got.capture);
        mismatches++;
      end
      if (got.pos !== want.pos) begin
        $error("byte_index: expected %0d, actual %0d", want.pos, got.pos);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %b, actual %b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  irp_in_if  req();
  irp_cfg_if cfg();
  irp_out_if rsp();

  i2c_remote_panel_responder DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cfg (cfg),
    .rsp (rsp)
  );

  panel_scoreboard sb;
  logic [7:0]      frame_q [$];
  int unsigned     sent_items;
  int unsigned     quiet_cycles;
  bit              no_idle;
  bit              hold_rsp;
  bit              hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every handshake is seen here, at the rising edge. Input beats are noted
  // before result beats, so a beat owed by this very edge is already queued.
  // The watchdog counts edges at which nothing moves on any channel.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg.valid && cfg.ready)
        sb.write_reg(cfg_idx_t'(cfg.index), cfg.data);
      if (req.valid && req.ready)
        sb.note_input(op_t'(req.op), req.data_byte, req.end_of_write, req.button_code);
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.out_byte, rsp.is_capture, rsp.byte_index, rsp.last_of_run});
      if ((cfg.valid && cfg.ready) || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. The receiver stalls at random unless idling is switched off.
  // On request it holds ready low for a long stretch, so that the run queue
  // fills up and the block pushes back on its input.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        hold_rsp  = 1'b0;
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp.ready = no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Offers one input beat and returns at the falling edge after acceptance.
  // Valid stays high on return, so back-to-back beats need no extra step.
  task automatic send(op_t op, logic [7:0] db, logic eow, logic [7:0] bc);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid        = 1'b1;
    req.op           = op;
    req.data_byte    = db;
    req.end_of_write = eow;
    req.button_code  = bc;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if (op != OP_NOP) sent_items++;
  endtask

  task automatic send_read();
    send(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Sends the bytes in frame_q as one master write. Reads and no-op beats may
  // land inside the frame; they must leave the partial frame alone.
  task automatic send_frame(bit interleave);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (interleave && i != 0 && $urandom_range(99) < 6)
        send_read();
      if (interleave && i != 0 && $urandom_range(99) < 3)
        send(OP_NOP, 8'($urandom), 1'($urandom), 8'($urandom));
      send(OP_WRITE, frame_q[i], i == frame_q.size() - 1, 8'($urandom));
    end
  endtask

  // Sets the last byte within the frame depth so that the XOR over those bytes, seeded with
  // the shifted own address, comes out zero; a bad frame gets one bit flipped.
  task automatic seal(bit good);
    int         k;
    logic [7:0] acc;
    k   = (frame_q.size() < FRAME_DEPTH) ? frame_q.size() - 1 : FRAME_DEPTH - 1;
    acc = {sb.own_address, 1'b0};
    for (int i = 0; i < k; i++) acc ^= frame_q[i];
    frame_q[k] = acc;
    if (!good) frame_q[k] ^= 8'(1 << $urandom_range(7));
  endtask

  task automatic build_frame(logic [7:0] h1, logic [7:0] h2, int len, bit good);
    frame_q = {BYTE_LEAD, h1, h2};
    while (frame_q.size() < len) frame_q.push_back(8'($urandom));
    seal(good);
  endtask

  // Lowers valid and waits until every owed beat has come. It then lets the
  // block settle, since a frame that owes nothing may still be in work.
  task automatic drain();
    req.valid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_registers(logic [6:0] own, logic [7:0] none, logic [7:0] status,
                               bit spare);
    cfg.valid = 1'b1;
    cfg.index = CFG_OWN_ADDRESS;
    cfg.data  = {1'($urandom), own};
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.index = CFG_NONE_CODE;
    cfg.data  = none;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.index = CFG_STATUS_CODE;
    cfg.data  = status;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    // The spare index has no register behind it; a write there changes nothing.
    if (spare) begin
      cfg.index = CFG_UNUSED;
      cfg.data  = 8'($urandom);
      do @(posedge clk); while (!cfg.ready);
      @(negedge clk);
    end
    cfg.valid = 1'b0;
  endtask

  task automatic pick_button_code(output logic [7:0] code);
    case ($urandom_range(2))
      0:       code = sb.none_code;
      1:       code = sb.status_code;
      default: code = 8'($urandom);
    endcase
  endtask

  // One random piece of traffic. The panel dialogue is weighted most heavily,
  // because it gets the remote into the waiting phase.
  task automatic random_scenario();
    int         r;
    int         len;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] code;
    r = $urandom_range(99);
    if (r < 28) begin
      code = ($urandom_range(9) < 7) ? sb.status_code : 8'($urandom);
      send(OP_BUTTON, 8'($urandom), 1'($urandom), code);
      h1 = $urandom_range(1) ? BYTE_ACK_REG : BYTE_BUTTON_REG;
      frame_q = {8'($urandom), h1, BYTE_ONE};
      send_frame(1'b1);
      send_read();
      build_frame(BYTE_STATUS_REG, BYTE_STATUS_LEN, $urandom_range(KEEP_BYTES, FRAME_DEPTH),
                  $urandom_range(9) != 0);
      send_frame(1'b1);
      if ($urandom_range(1)) send_read();
    end else if (r < 48) begin
      case ($urandom_range(2))
        0: begin
          h1 = BYTE_STATUS_REG;
          h2 = BYTE_STATUS_LEN;
        end
        1: begin
          h1 = BYTE_ACK_REG;
          h2 = BYTE_ONE;
        end
        default: begin
          h1 = 8'($urandom);
          h2 = 8'($urandom);
        end
      endcase
      // Now and then the frame runs past the depth and the tail is dropped.
      len = ($urandom_range(7) == 0) ? $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 4)
                                     : $urandom_range(4, FRAME_DEPTH);
      build_frame(h1, h2, len, $urandom_range(6) != 0);
      if ($urandom_range(5) == 0) frame_q[0] = 8'($urandom_range(1, 255));
      send_frame(1'b1);
    end else if (r < 63) begin
      case ($urandom_range(2))
        0: frame_q = {8'($urandom), BYTE_ACK_REG, BYTE_ONE};
        1: frame_q = {8'($urandom), BYTE_BUTTON_REG, BYTE_ONE};
        default: frame_q = {8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      send_frame(1'b1);
      send_read();
    end else if (r < 75) begin
      send_read();
    end else if (r < 85) begin
      pick_button_code(code);
      send(OP_BUTTON, 8'($urandom), 1'($urandom), code);
    end else if (r < 93) begin
      frame_q.delete();
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
      send_frame(1'b0);
    end else begin
      send(OP_NOP, 8'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    sb        = new();
    no_idle   = 1'b0;
    hold_rsp  = 1'b0;
    hold_done = 1'b0;
    rst       = 1'b1;
    req.valid        = 1'b0;
    req.op           = OP_NOP;
    req.data_byte    = 8'h00;
    req.end_of_write = 1'b0;
    req.button_code  = 8'h00;
    cfg.valid = 1'b0;
    cfg.index = CFG_OWN_ADDRESS;
    cfg.data  = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed dialogue under the reset register values.
    // First, a read straight after reset answers with the default ack twice.
    send_read();
    // A checked write to the ack register selects the alternate ack.
    build_frame(BYTE_ACK_REG, BYTE_ONE, 4, 1'b1);
    send_frame(1'b0);
    send_read();
    // A status-only button press, then a read setup. The setup moves the
    // remote to waiting, and the next read returns ack, data and checksum.
    send(OP_BUTTON, 8'h00, 1'b0, sb.status_code);
    frame_q = {8'hff, BYTE_ACK_REG, BYTE_ONE};
    send_frame(1'b0);
    send_read();
    send(OP_NOP, 8'hff, 1'b1, 8'hff);
    // The shortest status write captures the display and status bytes.
    build_frame(BYTE_STATUS_REG, BYTE_STATUS_LEN, KEEP_BYTES, 1'b1);
    frame_q[CAPTURE_FIRST]     = 8'hff;
    frame_q[CAPTURE_FIRST + 1] = 8'h00;
    seal(1'b1);
    send_frame(1'b0);
    send_read();
    drain();

    // Random phases, one register setting each. The first uses extreme values
    // and the second makes the none and status codes equal. The
    // third is random and the last returns to the reset values.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_registers(7'h7f, 8'hff, 8'h00, 1'b0);
        1: set_registers(7'h00, 8'h55, 8'h55, 1'b1);
        2: set_registers(7'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        default: set_registers(OWN_ADDRESS_RESET, NONE_CODE_RESET, STATUS_CODE_RESET, 1'b0);
      endcase
      // The second phase runs with no idling on either side.
      no_idle = (p == 1);
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) begin
        if (p == 2 && !hold_done && sent_items >= PHASE_ITEMS / 2) begin
          // Long receiver hold while reads keep coming, to fill the run queue.
          hold_done = 1'b1;
          hold_rsp  = 1'b1;
          repeat (HOLD_READS) send_read();
        end else if (p == 3 && sent_items >= PHASE_ITEMS / 2
                     && sent_items < PHASE_ITEMS / 2 + 8) begin
          // The sender pauses here until every owed beat has come.
          drain();
          random_scenario();
        end else begin
          random_scenario();
        end
      end
      // Close any open frame so that the next register write meets an empty one.
      if (sb.frame_len != 0) send(OP_WRITE, 8'($urandom), 1'b1, 8'($urandom));
      no_idle = 1'b0;
      drain();
    end

    $display("Summary: %0d input beats, %0d result beats checked, %0d capture runs.",
             sb.items, sb.beats, sb.captures);
    $display("Summary: %0d register writes over five settings, %0d mismatches.",
             sb.reg_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
